// ===== hdl/asbc_pkg.sv =====
// ----------------------------------------------------------------------------
// asbc_pkg
// Shared types and constants for the accelerometer static bias calibrator.
// ----------------------------------------------------------------------------
package asbc_pkg;

  localparam int NumAxes       = 3;
  localparam int GravityWidth  = 23;
  localparam int CfgIdxWidth   = 1;
  localparam int SampleCountRst = 800;
  localparam int GravityRst    = 642908;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegSampleCount = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegGravity     = 1'b1;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_START,
    ST_DIV,
    ST_BIAS,
    ST_LOAD
  } ctl_state_e;

  typedef struct packed {
    logic in_fire;
    logic div_start;
    logic bias_load;
    logic out_load;
    logic out_sel_held;
  } ctl_cmd_t;

  typedef struct packed {
    logic cal_hit;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== hdl/accel_static_bias_calibrator.sv =====
// ----------------------------------------------------------------------------
// accel_static_bias_calibrator
// Takes signed Q8.16 three-axis accelerometer beats and passes them through
// raw until the static bias is known. Beats with nonzero x and y are summed
// and counted; when the count reaches sample_count the per-axis average
// (truncated toward zero, z also less gravity) becomes the bias, and from
// that beat on every output is sample minus bias, saturated, with corrected
// set. Every beat gives one output beat. The block takes one beat per cycle
// while the input is not stalled. Results leave through a single output
// register, and the input stalls while a held result is stalled. The one beat
// that completes calibration stalls the input while the radix-2 divider runs
// all three axes side by side, one quotient bit a cycle, and until its result
// is loaded into the output register.
// Configuration is written through a plain write port: index 0 is
// sample_count, index 1 is gravity.
// ----------------------------------------------------------------------------
module accel_static_bias_calibrator #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COUNT_WIDTH  = 12
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  logic                                                     cfg_we_i,
  input  logic [asbc_pkg::CfgIdxWidth-1:0]                         cfg_idx_i,
  input  logic [((COUNT_WIDTH > asbc_pkg::GravityWidth) ?
                 COUNT_WIDTH : asbc_pkg::GravityWidth)-1:0]        cfg_data_i,
  input  logic                                                     in_valid_i,
  output logic                                                     in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]                                  accel_x_i,
  input  logic [SAMPLE_WIDTH-1:0]                                  accel_y_i,
  input  logic [SAMPLE_WIDTH-1:0]                                  accel_z_i,
  output logic                                                     out_valid_o,
  input  logic                                                     out_stall_i,
  output logic [SAMPLE_WIDTH-1:0]                                  out_x_o,
  output logic [SAMPLE_WIDTH-1:0]                                  out_y_o,
  output logic [SAMPLE_WIDTH-1:0]                                  out_z_o,
  output logic                                                     corrected_o
);

  localparam int CfgW = (COUNT_WIDTH > asbc_pkg::GravityWidth) ?
                        COUNT_WIDTH : asbc_pkg::GravityWidth;

  asbc_pkg::ctl_cmd_t cmd;
  asbc_pkg::dp_sts_t  sts;

  asbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  asbc_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .CFG_WIDTH    (CfgW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .corrected_o (corrected_o)
  );

endmodule

// ===== hdl/asbc_divider.sv =====
// ----------------------------------------------------------------------------
// asbc_divider
// Three-lane radix-2 restoring divider: signed sum over unsigned count,
// truncated toward zero and saturated to the sample width.
// ----------------------------------------------------------------------------
module asbc_divider #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COUNT_WIDTH  = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [SAMPLE_WIDTH+COUNT_WIDTH-1:0]   sum_i  [asbc_pkg::NumAxes],
  input  logic [COUNT_WIDTH-1:0]                div_i,
  output logic                                  done_o,
  output logic [SAMPLE_WIDTH-1:0]               quot_o [asbc_pkg::NumAxes]
);

  localparam int SumW = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int IterW = $clog2(SumW + 1);

  logic             busy_q, fix_q, done_q;
  logic [IterW-1:0] iter_q;

  logic [SumW-1:0]         quo_q [asbc_pkg::NumAxes];
  logic [COUNT_WIDTH-1:0]  rem_q [asbc_pkg::NumAxes];
  logic                    neg_q [asbc_pkg::NumAxes];
  logic [SAMPLE_WIDTH-1:0] res_q [asbc_pkg::NumAxes];

  function automatic logic [SAMPLE_WIDTH-1:0] sat_sum(input logic [SumW-1:0] v);
    logic ovf;
    ovf = (v[SumW-1:SAMPLE_WIDTH-1] != {(SumW-SAMPLE_WIDTH+1){v[SumW-1]}});
    return ovf ? {v[SumW-1], {(SAMPLE_WIDTH-1){~v[SumW-1]}}} : v[SAMPLE_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= IterW'(SumW);
      end else if (busy_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == IterW'(1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end
    end
  end

  for (genvar a = 0; a < asbc_pkg::NumAxes; a++) begin : g_lane
    logic [COUNT_WIDTH:0] shifted;
    logic                 fits;

    assign shifted = {rem_q[a], quo_q[a][SumW-1]};
    assign fits    = (shifted >= {1'b0, div_i});

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        neg_q[a] <= sum_i[a][SumW-1];
        quo_q[a] <= sum_i[a][SumW-1] ? (~sum_i[a] + 1'b1) : sum_i[a];
        rem_q[a] <= '0;
      end else if (busy_q) begin
        rem_q[a] <= fits ? COUNT_WIDTH'(shifted - {1'b0, div_i})
                         : shifted[COUNT_WIDTH-1:0];
        quo_q[a] <= {quo_q[a][SumW-2:0], fits};
      end
      // sign fix and clamp once the quotient magnitude is complete
      if (fix_q) begin
        res_q[a] <= sat_sum(neg_q[a] ? (~quo_q[a] + 1'b1) : quo_q[a]);
      end
    end

    assign quot_o[a] = res_q[a];
  end

  assign done_o = done_q;

endmodule

// ===== hdl/asbc_datapath.sv =====
// ----------------------------------------------------------------------------
// asbc_datapath
// Configuration registers, accumulators, bias registers, correction and the
// output register of the bias calibrator.
// ----------------------------------------------------------------------------
module asbc_datapath #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COUNT_WIDTH  = 12,
  parameter int CFG_WIDTH    = 23
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [asbc_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]               cfg_data_i,
  input  logic [SAMPLE_WIDTH-1:0]            accel_x_i,
  input  logic [SAMPLE_WIDTH-1:0]            accel_y_i,
  input  logic [SAMPLE_WIDTH-1:0]            accel_z_i,
  input  asbc_pkg::ctl_cmd_t                 cmd_i,
  output asbc_pkg::dp_sts_t                  sts_o,
  output logic [SAMPLE_WIDTH-1:0]            out_x_o,
  output logic [SAMPLE_WIDTH-1:0]            out_y_o,
  output logic [SAMPLE_WIDTH-1:0]            out_z_o,
  output logic                               corrected_o
);

  localparam int SumW  = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int BiasW = SAMPLE_WIDTH + 1;
  localparam int DiffW = SAMPLE_WIDTH + 2;
  localparam int GravW = asbc_pkg::GravityWidth;
  localparam int BzW   = ((SAMPLE_WIDTH > GravW) ? SAMPLE_WIDTH : GravW) + 2;

  logic [COUNT_WIDTH-1:0]  sample_count_q;
  logic [GravW-1:0]        gravity_q;
  logic [COUNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic                    calibrated_q;
  logic                    corr_q;
  logic                    take;

  logic [SAMPLE_WIDTH-1:0] smp    [asbc_pkg::NumAxes];
  logic [SAMPLE_WIDTH-1:0] held_q [asbc_pkg::NumAxes];
  logic [SumW-1:0]         sum_q  [asbc_pkg::NumAxes];
  logic [BiasW-1:0]        bias_q [asbc_pkg::NumAxes];
  logic [BiasW-1:0]        bias_d [asbc_pkg::NumAxes];
  logic [SAMPLE_WIDTH-1:0] out_q  [asbc_pkg::NumAxes];
  logic [SAMPLE_WIDTH-1:0] out_d  [asbc_pkg::NumAxes];
  logic [SAMPLE_WIDTH-1:0] quot   [asbc_pkg::NumAxes];
  logic [BzW-1:0]          bz_wide;

  function automatic logic [SAMPLE_WIDTH-1:0] sat_diff(input logic [DiffW-1:0] v);
    logic ovf;
    ovf = (v[DiffW-1:SAMPLE_WIDTH-1] != {(DiffW-SAMPLE_WIDTH+1){v[DiffW-1]}});
    return ovf ? {v[DiffW-1], {(SAMPLE_WIDTH-1){~v[DiffW-1]}}} : v[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic logic [BiasW-1:0] sat_bias(input logic [BzW-1:0] v);
    logic ovf;
    ovf = (v[BzW-1:BiasW-1] != {(BzW-BiasW+1){v[BzW-1]}});
    return ovf ? {v[BzW-1], {(BiasW-1){~v[BzW-1]}}} : v[BiasW-1:0];
  endfunction

  assign smp[0] = accel_x_i;
  assign smp[1] = accel_y_i;
  assign smp[2] = accel_z_i;

  // a sample counts toward the average only with nonzero x and y
  assign take  = !calibrated_q && (accel_x_i != '0) && (accel_y_i != '0);
  assign cnt_d = cnt_q + COUNT_WIDTH'(take);

  assign sts_o.cal_hit = !calibrated_q && (cnt_d != '0) && (cnt_d == sample_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= COUNT_WIDTH'(asbc_pkg::SampleCountRst);
      gravity_q      <= GravW'(asbc_pkg::GravityRst);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        asbc_pkg::RegSampleCount: sample_count_q <= cfg_data_i[COUNT_WIDTH-1:0];
        asbc_pkg::RegGravity:     gravity_q      <= cfg_data_i[GravW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      calibrated_q <= 1'b0;
      corr_q       <= 1'b0;
      for (int a = 0; a < asbc_pkg::NumAxes; a++) begin
        sum_q[a]  <= '0;
        bias_q[a] <= '0;
      end
    end else begin
      if (cmd_i.in_fire && take) begin
        cnt_q <= cnt_d;
        for (int a = 0; a < asbc_pkg::NumAxes; a++) begin
          sum_q[a] <= sum_q[a] + {{COUNT_WIDTH{smp[a][SAMPLE_WIDTH-1]}}, smp[a]};
        end
      end
      if (cmd_i.bias_load) begin
        calibrated_q <= 1'b1;
        for (int a = 0; a < asbc_pkg::NumAxes; a++) begin
          bias_q[a] <= bias_d[a];
        end
      end
      if (cmd_i.out_load) begin
        corr_q <= calibrated_q;
      end
    end
  end

  // z bias: clamped average less gravity, clamped to the bias width
  assign bz_wide = {{(BzW-SAMPLE_WIDTH){quot[2][SAMPLE_WIDTH-1]}}, quot[2]}
                 - {{(BzW-GravW){1'b0}}, gravity_q};

  assign bias_d[0] = {quot[0][SAMPLE_WIDTH-1], quot[0]};
  assign bias_d[1] = {quot[1][SAMPLE_WIDTH-1], quot[1]};
  assign bias_d[2] = sat_bias(bz_wide);

  for (genvar a = 0; a < asbc_pkg::NumAxes; a++) begin : g_axis
    logic [SAMPLE_WIDTH-1:0] src;
    logic [DiffW-1:0]        diff;

    assign src  = cmd_i.out_sel_held ? held_q[a] : smp[a];
    assign diff = {{2{src[SAMPLE_WIDTH-1]}}, src} - {bias_q[a][BiasW-1], bias_q[a]};
    assign out_d[a] = calibrated_q ? sat_diff(diff) : src;

    always_ff @(posedge clk_i) begin
      if (cmd_i.in_fire) begin
        held_q[a] <= smp[a];
      end
      if (cmd_i.out_load) begin
        out_q[a] <= out_d[a];
      end
    end
  end

  asbc_divider #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .sum_i   (sum_q),
    .div_i   (cnt_q),
    .done_o  (sts_o.div_done),
    .quot_o  (quot)
  );

  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
  assign corrected_o = corr_q;

endmodule

// ===== hdl/asbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// asbc_ctrl
// Sequencer for the bias calibrator: stream handshakes, divide start, bias
// load and the output register's valid flag.
// ----------------------------------------------------------------------------
module asbc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  asbc_pkg::dp_sts_t   sts_i,
  output asbc_pkg::ctl_cmd_t  cmd_o
);

  asbc_pkg::ctl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 in_fire;

  // output register can take a beat when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      asbc_pkg::ST_RUN:   if (in_fire && sts_i.cal_hit) state_d = asbc_pkg::ST_START;
      asbc_pkg::ST_START: state_d = asbc_pkg::ST_DIV;
      asbc_pkg::ST_DIV:   if (sts_i.div_done) state_d = asbc_pkg::ST_BIAS;
      asbc_pkg::ST_BIAS:  state_d = asbc_pkg::ST_LOAD;
      asbc_pkg::ST_LOAD:  if (out_free) state_d = asbc_pkg::ST_RUN;
      default:            state_d = asbc_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_stall_o = !((state_q == asbc_pkg::ST_RUN) && out_free);
    in_fire    = in_valid_i && !in_stall_o;
    cmd_o      = '0;
    cmd_o.in_fire = in_fire;
    unique case (state_q)
      asbc_pkg::ST_RUN:   cmd_o.out_load = in_fire && !sts_i.cal_hit;
      asbc_pkg::ST_START: cmd_o.div_start = 1'b1;
      asbc_pkg::ST_DIV:   ;
      asbc_pkg::ST_BIAS:  cmd_o.bias_load = 1'b1;
      asbc_pkg::ST_LOAD: begin
        cmd_o.out_load     = out_free;
        cmd_o.out_sel_held = 1'b1;
      end
      default: ;
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asbc_pkg::ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/asbc_checker.sv =====
// ----------------------------------------------------------------------------
// asbc_checker
// Port-level checks for the bias calibrator, bound to the top level.
// ----------------------------------------------------------------------------
module asbc_checker #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COUNT_WIDTH  = 12
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [SAMPLE_WIDTH-1:0] out_x_o,
  input logic [SAMPLE_WIDTH-1:0] out_y_o,
  input logic [SAMPLE_WIDTH-1:0] out_z_o,
  input logic                    corrected_o
);

  localparam int CntW = COUNT_WIDTH;

  // a stalled output beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o) && $stable(corrected_o))
    else $error("output payload changed while stalled");

  // once a corrected beat is delivered, no raw beat follows
  a_corr_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && corrected_o |=> !out_valid_o || corrected_o)
    else $error("raw beat after calibration");

  // an accepted beat with an empty output either shows up or holds the input
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o && (CntW > 0) |=> out_valid_o || in_stall_o)
    else $error("accepted beat lost");

endmodule

bind accel_static_bias_calibrator asbc_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH),
  .COUNT_WIDTH  (COUNT_WIDTH)
) u_asbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o),
  .corrected_o (corrected_o)
);
